@@ rtl/core/mpfd_pkg.sv @@
// Shared constants, types and command codes of the page frame store.
`timescale 1ns / 1ps
`default_nettype none
package mpfd_pkg;

    localparam int COLUMNS     = 96;
    localparam int ROWS        = 65;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(COLUMNS + 1);
    localparam int RW          = $clog2(ROWS + 1);
    localparam int PW          = $clog2(PAGES + 1);
    localparam int SW          = 12;
    localparam int QDEPTH      = 2;
    localparam int QAW         = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        MODE_PIXEL   = 3'd0,
        MODE_OUTLINE = 3'd1,
        MODE_FILL    = 3'd2,
        MODE_SCREEN  = 3'd3,
        MODE_READ    = 3'd4,
        MODE_STREAM  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        OP_RECT   = 2'd0,
        OP_SCREEN = 2'd1,
        OP_READ   = 2'd2,
        OP_STREAM = 2'd3
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            ink;
        logic            oor;
        logic [CW-1:0]   cx0;
        logic [CW-1:0]   cx1;
        logic [RW-1:0]   cy0;
        logic [RW-1:0]   cy1;
    } t_cmd;

    typedef struct packed {
        logic sweeping;
    } t_back_stat;

endpackage
`default_nettype wire

@@ rtl/core/mpfd_chan_if.sv @@
// Command and result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface mpfd_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        mode;
    logic signed [9:0] x_pos;
    logic signed [9:0] y_pos;
    logic signed [9:0] width_span;
    logic signed [9:0] height_span;
    logic              ink;
    modport source (output valid, mode, x_pos, y_pos, width_span, height_span, ink,
                    input ready);
    modport sink   (input valid, mode, x_pos, y_pos, width_span, height_span, ink,
                    output ready);
endinterface

interface mpfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       pixel_value;
    logic       out_of_range;
    logic       end_of_frame;
    modport source (output valid, data_byte, pixel_value, out_of_range, end_of_frame,
                    input ready);
    modport sink   (input valid, data_byte, pixel_value, out_of_range, end_of_frame,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/mpfd_front.sv @@
// Command front end: accepts items, splits them into clipped rectangles and ops.
`timescale 1ns / 1ps
`default_nettype none
module mpfd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mpfd_in_if.sink                i_cmd,
    input  wire logic              i_q_full,
    input  wire mpfd_pkg::t_back_stat i_stat,
    output logic                   o_push,
    output mpfd_pkg::t_cmd         o_entry
);
    import mpfd_pkg::*;

    logic                 r_busy;
    logic [1:0]           r_phase;
    t_mode                r_mode;
    logic signed [SW-1:0] r_x, r_y, r_w, r_h;
    logic                 r_ink;

    logic signed [SW-1:0] x0, x1, y0, y1;
    logic                 keep, last, advance;

    function automatic logic [CW-1:0] clamp_x(input logic signed [SW-1:0] v);
        if (v < 0)
            return '0;
        else if (v > COLUMNS)
            return CW'(COLUMNS);
        else
            return v[CW-1:0];
    endfunction

    function automatic logic [RW-1:0] clamp_y(input logic signed [SW-1:0] v);
        if (v < 0)
            return '0;
        else if (v > ROWS)
            return RW'(ROWS);
        else
            return v[RW-1:0];
    endfunction

    assign i_cmd.ready = !r_busy && !i_stat.sweeping;

    always_comb begin
        x0 = r_x;
        x1 = r_x + SW'(1);
        y0 = r_y;
        y1 = r_y + SW'(1);
        case (r_mode)
            MODE_FILL: begin
                x1 = r_x + r_w;
                y1 = r_y + r_h;
            end
            MODE_OUTLINE: begin
                case (r_phase)
                    2'd0: begin
                        x1 = r_x + r_w;
                    end
                    2'd1: begin
                        x1 = r_x + r_w;
                        y0 = r_y + r_h - SW'(1);
                        y1 = r_y + r_h;
                    end
                    2'd2: begin
                        y1 = r_y + r_h;
                    end
                    default: begin
                        x0 = r_x + r_w - SW'(1);
                        x1 = r_x + r_w;
                        y1 = r_y + r_h;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_entry.ink = r_ink;
        o_entry.cx0 = clamp_x(x0);
        o_entry.cx1 = clamp_x(x1);
        o_entry.cy0 = clamp_y(y0);
        o_entry.cy1 = clamp_y(y1);
        o_entry.oor = (r_x < 0) || (r_x >= COLUMNS) || (r_y < 0) || (r_y >= ROWS);
        keep        = 1'b1;
        case (r_mode)
            MODE_SCREEN: o_entry.op = OP_SCREEN;
            MODE_READ:   o_entry.op = OP_READ;
            MODE_STREAM: o_entry.op = OP_STREAM;
            default: begin
                o_entry.op = OP_RECT;
                // drop rectangles that clip away entirely
                keep = (o_entry.cx0 < o_entry.cx1) && (o_entry.cy0 < o_entry.cy1);
            end
        endcase
    end

    assign last    = (r_mode != MODE_OUTLINE) || (r_phase == 2'd3);
    assign o_push  = r_busy && keep && !i_q_full;
    assign advance = r_busy && (!keep || !i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            // unused mode codes are dropped here
            r_busy  <= (i_cmd.mode <= MODE_STREAM);
            r_phase <= '0;
        end else if (advance) begin
            if (last)
                r_busy <= 1'b0;
            r_phase <= r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_mode <= t_mode'(i_cmd.mode);
            r_x    <= SW'(i_cmd.x_pos);
            r_y    <= SW'(i_cmd.y_pos);
            r_w    <= SW'(i_cmd.width_span);
            r_h    <= SW'(i_cmd.height_span);
            r_ink  <= i_cmd.ink;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/mpfd_queue.sv @@
// Two-entry command queue between front end and drawing engine.
`timescale 1ns / 1ps
`default_nettype none
module mpfd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mpfd_pkg::t_cmd i_entry,
    output logic                o_full,
    output logic                o_valid,
    output mpfd_pkg::t_cmd      o_entry,
    input  wire logic           i_pop
);
    import mpfd_pkg::*;

    t_cmd           r_slot [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wptr <= r_wptr + 1'b1;
            if (i_pop)
                r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)
                r_count <= r_count + 1'b1;
            else if (!i_push && i_pop)
                r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_slot[r_wptr] <= i_entry;
    end

endmodule
`default_nettype wire

@@ rtl/core/mpfd_back.sv @@
// Drawing engine: owns the frame memory, runs byte sweeps and forms results.
`timescale 1ns / 1ps
`default_nettype none
module mpfd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire mpfd_pkg::t_cmd i_entry,
    output logic                o_pop,
    output mpfd_pkg::t_back_stat o_stat,
    mpfd_out_if.source          o_res
);
    import mpfd_pkg::*;

    typedef enum logic [5:0] {
        S_FILL    = 6'b000001,
        S_IDLE    = 6'b000010,
        S_RECT_RD = 6'b000100,
        S_RECT_WR = 6'b001000,
        S_LOOK    = 6'b010000,
        S_RESULT  = 6'b100000
    } t_state;

    t_state         r_state;
    t_cmd           r_cmd;
    logic [AW-1:0]  r_addr, r_base, r_sptr;
    logic [CW-1:0]  r_col;
    logic [PW-1:0]  r_page;
    logic [7:0]     r_fill;
    logic [7:0]     r_rdata;
    logic [7:0]     r_mem [STORE_BYTES];

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_pix, r_out_oor, r_out_eof;

    logic           out_free, mem_we, mem_re;
    logic [7:0]     mem_wdata, mask;
    logic [2:0]     lo, hi;
    logic [RW-1:0]  cy1m1;
    logic [PW-1:0]  pstart, pend, e_page;
    logic [CW-1:0]  cx1m1;
    logic [AW-1:0]  e_base, n_base;

    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.sweeping = (r_state == S_FILL);

    assign cy1m1  = r_cmd.cy1 - 1'b1;
    assign cx1m1  = r_cmd.cx1 - 1'b1;
    assign pstart = PW'(r_cmd.cy0 >> 3);
    assign pend   = PW'(cy1m1 >> 3);
    assign lo     = (r_page == pstart) ? r_cmd.cy0[2:0] : 3'd0;
    assign hi     = (r_page == pend) ? cy1m1[2:0] : 3'd7;
    assign mask   = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    assign n_base = r_base + AW'(COLUMNS);

    assign e_page = PW'(i_entry.cy0 >> 3);
    assign e_base = AW'(e_page * COLUMNS);

    assign mem_we    = (r_state == S_FILL) || (r_state == S_RECT_WR);
    assign mem_re    = (r_state == S_RECT_RD) || (r_state == S_LOOK);
    assign mem_wdata = (r_state == S_FILL) ? r_fill
                     : (r_cmd.ink ? (r_rdata | mask) : (r_rdata & ~mask));

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[r_addr] <= mem_wdata;
        if (mem_re)
            r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_fill      <= 8'h00;
            r_sptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_RESULT) && out_free)
                r_out_valid <= 1'b1;
            else if (o_res.ready)
                r_out_valid <= 1'b0;
            case (r_state)
                S_FILL: begin
                    if (r_addr == AW'(STORE_BYTES - 1))
                        r_state <= S_IDLE;
                    r_addr <= r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd  <= i_entry;
                        r_col  <= i_entry.cx0;
                        r_page <= e_page;
                        r_base <= e_base;
                        case (i_entry.op)
                            OP_RECT: begin
                                r_addr  <= e_base + AW'(i_entry.cx0);
                                r_state <= S_RECT_RD;
                            end
                            OP_SCREEN: begin
                                r_addr  <= '0;
                                r_fill  <= i_entry.ink ? 8'hFF : 8'h00;
                                r_state <= S_FILL;
                            end
                            OP_READ: begin
                                r_addr  <= e_base + AW'(i_entry.cx0);
                                // skip the lookup for an off-screen read
                                r_state <= i_entry.oor ? S_RESULT : S_LOOK;
                            end
                            default: begin
                                r_addr  <= r_sptr;
                                r_state <= S_LOOK;
                            end
                        endcase
                    end
                end
                S_RECT_RD: r_state <= S_RECT_WR;
                S_RECT_WR: begin
                    if (r_col == cx1m1) begin
                        if (r_page == pend) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_cmd.cx0;
                            r_page  <= r_page + 1'b1;
                            r_base  <= n_base;
                            r_addr  <= n_base + AW'(r_cmd.cx0);
                            r_state <= S_RECT_RD;
                        end
                    end else begin
                        r_col   <= r_col + 1'b1;
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_RECT_RD;
                    end
                end
                S_LOOK: r_state <= S_RESULT;
                S_RESULT: begin
                    if (out_free) begin
                        if (r_cmd.op == OP_STREAM) begin
                            r_sptr <= (r_sptr == AW'(STORE_BYTES - 1)) ? '0
                                                                        : r_sptr + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESULT) && out_free) begin
            if (r_cmd.op == OP_STREAM) begin
                r_out_byte <= r_rdata;
                r_out_pix  <= 1'b0;
                r_out_oor  <= 1'b0;
                r_out_eof  <= (r_sptr == AW'(STORE_BYTES - 1));
            end else begin
                r_out_byte <= 8'h00;
                r_out_pix  <= !r_cmd.oor && r_rdata[r_cmd.cy0[2:0]];
                r_out_oor  <= r_cmd.oor;
                r_out_eof  <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.data_byte    = r_out_byte;
    assign o_res.pixel_value  = r_out_pix;
    assign o_res.out_of_range = r_out_oor;
    assign o_res.end_of_frame = r_out_eof;

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !o_pop)
        else $error("command taken during memory sweep");

    a_sptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sptr < AW'(STORE_BYTES))
        else $error("stream pointer beyond frame store");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RECT_WR) |-> (r_addr < AW'(STORE_BYTES)))
        else $error("rectangle write beyond frame store");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && !out_free) |=> (r_state == S_RESULT))
        else $error("result dropped while output busy");

endmodule
`default_nettype wire

@@ rtl/core/mono_page_framebuffer_draw.sv @@
// Monochrome page-organized frame store with drawing commands.
//
// i_cmd takes one command item per valid/ready handshake: pixel, rectangle
// outline, rectangle fill, fill screen, read pixel or next frame byte.
// o_res gives one result item for read pixel and next frame byte only.
// A front end turns each drawing command into clipped rectangle jobs (an
// outline is four one-pixel-wide rectangles) and the others into ops, and
// queues them two deep; the drawing engine behind the queue works on a
// single-port frame memory. A rectangle does a read-modify-write of every
// byte it touches on the one memory port; fill screen writes all 864
// bytes, one a cycle. An off-screen read skips the memory lookup; other
// reads and next frame byte read the memory before the result is
// registered. After reset the engine clears the 864 bytes; i_cmd.ready
// stays low during that sweep and during a fill screen.
// A stalled receiver holds the result in the output register; the front
// end and queue keep taking commands until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module mono_page_framebuffer_draw (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpfd_in_if.sink   i_cmd,
    mpfd_out_if.source o_res
);
    import mpfd_pkg::*;

    t_cmd       front_entry, queue_entry;
    t_back_stat back_stat;
    logic       push, pop, q_full, q_valid;

    mpfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_q_full(q_full),
        .i_stat  (back_stat),
        .o_push  (push),
        .o_entry (front_entry)
    );

    mpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (queue_entry),
        .i_pop   (pop)
    );

    mpfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_entry  (queue_entry),
        .o_pop    (pop),
        .o_stat   (back_stat),
        .o_res    (o_res)
    );

endmodule
`default_nettype wire

@@ bench/mpfd_tb_pkg.sv @@
// Scoreboard class for the page frame store bench: frame image, stream pointer and result queue.
`timescale 1ns / 1ps
package mpfd_tb_pkg;
    import mpfd_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       pixel_value;
        logic       out_of_range;
        logic       end_of_frame;
    } t_pixel_result;

    class frame_scoreboard;
        logic [7:0]    image [STORE_BYTES];
        int            next_byte;
        t_pixel_result pending[$];
        int            errors;

        function new();
            foreach (image[k]) image[k] = 8'h00;
            next_byte = 0;
            errors = 0;
        endfunction

        function void plot(int x, int y, logic ink);
            int idx;
            if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS) return;
            idx = x + (y / 8) * COLUMNS;
            image[idx][y % 8] = ink;
        endfunction

        // Mirror one accepted command in the image and queue any result it gives.
        function void note_command(logic [2:0] mode, int x, int y, int w, int h, logic ink);
            t_pixel_result r;
            int xe, ye;
            r = '{8'h00, 1'b0, 1'b0, 1'b0};
            case (mode)
                MODE_PIXEL: plot(x, y, ink);
                MODE_OUTLINE: begin
                    xe = (x + w > COLUMNS) ? COLUMNS : x + w;
                    for (int i = (x < 0 ? 0 : x); i < xe; i++) begin
                        plot(i, y, ink);
                        plot(i, y + h - 1, ink);
                    end
                    ye = (y + h > ROWS) ? ROWS : y + h;
                    for (int j = (y < 0 ? 0 : y); j < ye; j++) begin
                        plot(x, j, ink);
                        plot(x + w - 1, j, ink);
                    end
                end
                MODE_FILL: begin
                    xe = (x + w > COLUMNS) ? COLUMNS : x + w;
                    ye = (y + h > ROWS) ? ROWS : y + h;
                    for (int j = (y < 0 ? 0 : y); j < ye; j++)
                        for (int i = (x < 0 ? 0 : x); i < xe; i++)
                            plot(i, j, ink);
                end
                MODE_SCREEN: foreach (image[k]) image[k] = ink ? 8'hFF : 8'h00;
                MODE_READ: begin
                    if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS) begin
                        r.out_of_range = 1'b1;
                    end else begin
                        r.pixel_value = image[x + (y / 8) * COLUMNS][y % 8];
                    end
                    pending.push_back(r);
                end
                MODE_STREAM: begin
                    r.data_byte = image[next_byte];
                    r.end_of_frame = (next_byte == STORE_BYTES - 1);
                    next_byte = (next_byte + 1 >= STORE_BYTES) ? 0 : next_byte + 1;
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result exp;
            if (pending.size() == 0) begin
                $error("unexpected result: data_byte %h", got.data_byte);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.data_byte !== exp.data_byte) begin
                $error("data_byte expected %h actual %h", exp.data_byte, got.data_byte);
                errors++;
            end
            if (got.pixel_value !== exp.pixel_value) begin
                $error("pixel_value expected %b actual %b", exp.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.out_of_range !== exp.out_of_range) begin
                $error("out_of_range expected %b actual %b",
                       exp.out_of_range, got.out_of_range);
                errors++;
            end
            if (got.end_of_frame !== exp.end_of_frame) begin
                $error("end_of_frame expected %b actual %b",
                       exp.end_of_frame, got.end_of_frame);
                errors++;
            end
        endfunction
    endclass
endpackage

@@ bench/mono_page_framebuffer_draw_test.sv @@
// Top of the page frame store bench: clock, reset, command and result drivers, watchdog.
`timescale 1ns / 1ps
module mono_page_framebuffer_draw_test;
    import mpfd_pkg::*;
    import mpfd_tb_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic sending_done;
    int   quiet_cycles;
    frame_scoreboard board;

    mpfd_in_if  cmd_ch ();
    mpfd_out_if res_ch ();

    mono_page_framebuffer_draw DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_command(logic [2:0] mode, int x, int y, int w, int h, logic ink);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= mode;
        cmd_ch.x_pos       <= x[9:0];
        cmd_ch.y_pos       <= y[9:0];
        cmd_ch.width_span  <= w[9:0];
        cmd_ch.height_span <= h[9:0];
        cmd_ch.ink         <= ink;
        do @(posedge i_clk); while (!cmd_ch.ready);
        board.note_command(mode, x, y, w, h, ink);
    endtask

    function automatic int any10();
        return $signed(10'($urandom));
    endfunction

    // Mostly on-screen shapes with small sizes, some wild coordinates.
    task automatic send_random();
        int roll, x, y, w, h;
        logic [2:0] mode;
        roll = $urandom_range(0, 99);
        if (roll < 20) mode = MODE_PIXEL;
        else if (roll < 32) mode = MODE_OUTLINE;
        else if (roll < 42) mode = MODE_FILL;
        else if (roll < 43) mode = MODE_SCREEN;
        else if (roll < 68) mode = MODE_READ;
        else if (roll < 96) mode = MODE_STREAM;
        else mode = 3'($urandom_range(6, 7));
        if ($urandom_range(0, 9) < 8) begin
            x = $urandom_range(0, COLUMNS + 4) - 2;
            y = $urandom_range(0, ROWS + 4) - 2;
            w = $urandom_range(0, 20) - 2;
            h = $urandom_range(0, 20) - 2;
        end else begin
            x = any10(); y = any10(); w = any10(); h = any10();
        end
        send_command(mode, x, y, w, h, 1'($urandom));
    endtask

    // Drop valid, then hold until every expected result has come.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        sending_done = 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.mode <= MODE_PIXEL;
        cmd_ch.x_pos <= '0;
        cmd_ch.y_pos <= '0;
        cmd_ch.width_span <= '0;
        cmd_ch.height_span <= '0;
        cmd_ch.ink <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, clipping, extremes, every mode.
        send_command(MODE_READ, 0, 0, 0, 0, 0);
        send_command(MODE_PIXEL, 0, 0, 0, 0, 1);
        send_command(MODE_PIXEL, COLUMNS - 1, ROWS - 1, 0, 0, 1);
        send_command(MODE_PIXEL, -512, 511, 0, 0, 1);
        send_command(MODE_READ, COLUMNS - 1, ROWS - 1, 0, 0, 0);
        send_command(MODE_READ, COLUMNS, 0, 0, 0, 0);
        send_command(MODE_READ, -1, -512, 0, 0, 0);
        send_command(MODE_READ, 511, ROWS, 0, 0, 0);
        send_command(MODE_OUTLINE, -3, -3, 511, 511, 1);
        send_command(MODE_OUTLINE, 10, 10, 0, 5, 1);
        send_command(MODE_OUTLINE, 20, 20, 5, -512, 1);
        send_command(MODE_FILL, 30, 60, 8, 10, 1);
        send_command(MODE_FILL, 5, 5, -1, 8, 1);
        send_command(MODE_FILL, -512, -512, 511, 511, 0);
        send_command(MODE_READ, 0, 64, 0, 0, 0);
        send_command(MODE_SCREEN, 0, 0, 0, 0, 1);
        send_command(3'd6, 1, 1, 1, 1, 0);
        send_command(3'd7, 0, 0, 0, 0, 1);
        for (int k = 0; k < STORE_BYTES + 2; k++)
            send_command(MODE_STREAM, 0, 0, 0, 0, 0);
        send_command(MODE_SCREEN, 0, 0, 0, 0, 0);
        wait_drained();

        for (int n = 0; n < 900; n++) begin
            if (n == 450) wait_drained();
            send_random();
        end
        cmd_ch.valid <= 1'b0;
        sending_done <= 1'b1;
    end

    // Result side: random stalls, check each accepted item.
    initial begin
        t_pixel_result got;
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.data_byte    = res_ch.data_byte;
            got.pixel_value  = res_ch.pixel_value;
            got.out_of_range = res_ch.out_of_range;
            got.end_of_frame = res_ch.end_of_frame;
            board.check_result(got);
        end
    end

    // Watchdog and end of run.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (sending_done && board.pending.size() == 0) begin
                repeat (2000) @(posedge i_clk);
                if (board.errors == 0 && board.pending.size() == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end
endmodule

@@ filelist.f @@
rtl/core/mpfd_pkg.sv
rtl/core/mpfd_chan_if.sv
rtl/core/mpfd_front.sv
rtl/core/mpfd_queue.sv
rtl/core/mpfd_back.sv
rtl/core/mono_page_framebuffer_draw.sv
bench/mpfd_tb_pkg.sv
bench/mono_page_framebuffer_draw_test.sv
